/* rtl/vnu_pkg.sv */
`default_nettype none
package vnu_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CompW     = 32;
  localparam int unsigned SqW       = 64;
  localparam int unsigned SumW      = SqW + 1;
  localparam int unsigned RootW     = 32;
  localparam int unsigned LenW      = RootW + 1;
  localparam int unsigned QuotW     = 31;
  localparam int unsigned FracBits  = 30;
  localparam int unsigned RemW      = CompW + FracBits;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [LenW-1:0] OneQ16 = LenW'(33'h0_0001_0000);
  localparam logic [LenW-1:0] LenMax = LenW'(33'h1_0000_0000);

  // Register indexes of the configuration port.
  localparam logic [1:0] RegZeroThr = 2'd0;
  localparam logic [1:0] RegUnitTol = 2'd1;

  // An item as it leaves the front part: exact sum of squares,
  // component magnitudes and signs.
  typedef struct packed {
    logic [SumW-1:0]                 sum;
    logic [NumLanes-1:0][CompW-1:0]  mag;
    logic [NumLanes-1:0]             neg;
  } fe_item_t;

  typedef struct packed {
    logic [31:0] zero_thr;
    logic [15:0] unit_tol;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/vnu_front.sv */
`default_nettype none
module vnu_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [127:0]        in_data_i,
  output logic                     item_valid_o,
  input  wire logic                item_ready_i,
  output vnu_pkg::fe_item_t        item_o
);

  logic                                          a_v_q;
  logic [127:0]                                  a_data_q;
  logic                                          b_v_q;
  logic [vnu_pkg::NumLanes-1:0][vnu_pkg::SqW-1:0]   b_sq_q;
  logic [vnu_pkg::NumLanes-1:0][vnu_pkg::CompW-1:0] b_mag_q;
  logic [vnu_pkg::NumLanes-1:0]                  b_neg_q;
  logic                                          c_v_q;
  vnu_pkg::fe_item_t                             c_item_q;

  logic [vnu_pkg::NumLanes-1:0][vnu_pkg::SqW-1:0]   sq_d;
  logic [vnu_pkg::NumLanes-1:0][vnu_pkg::CompW-1:0] mag_d;
  logic [vnu_pkg::NumLanes-1:0]                  neg_d;
  logic [vnu_pkg::SumW-1:0]                      sum_d;
  logic                                          en;

  assign en = !c_v_q || item_ready_i;
  assign in_ready_o = en;

  // Magnitude of each component and its square.
  always_comb begin
    for (int i = 0; i < vnu_pkg::NumLanes; i++) begin
      neg_d[i] = a_data_q[i*vnu_pkg::CompW + vnu_pkg::CompW - 1];
      mag_d[i] = neg_d[i] ? (~a_data_q[i*vnu_pkg::CompW +: vnu_pkg::CompW] + 32'd1)
                          : a_data_q[i*vnu_pkg::CompW +: vnu_pkg::CompW];
      sq_d[i]  = {32'd0, mag_d[i]} * {32'd0, mag_d[i]};
    end
  end

  assign sum_d = {1'b0, b_sq_q[0]} + {1'b0, b_sq_q[1]} + {1'b0, b_sq_q[2]} + {1'b0, b_sq_q[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_data_q     <= in_data_i;
      b_sq_q       <= sq_d;
      b_mag_q      <= mag_d;
      b_neg_q      <= neg_d;
      c_item_q.sum <= sum_d;
      c_item_q.mag <= b_mag_q;
      c_item_q.neg <= b_neg_q;
    end
  end

  assign item_valid_o = c_v_q;
  assign item_o       = c_item_q;

endmodule
`default_nettype wire

/* rtl/vnu_fifo.sv */
`default_nettype none
module vnu_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  vnu_pkg::fe_item_t      push_item_i,
  input  wire logic              pop_i,
  output vnu_pkg::fe_item_t      head_o,
  output logic                   full_o,
  output logic                   empty_o
);

  vnu_pkg::fe_item_t                 mem_q [vnu_pkg::QueueDepth];
  logic [vnu_pkg::QueuePtrW-1:0]     wr_ptr_q;
  logic [vnu_pkg::QueuePtrW-1:0]     rd_ptr_q;
  logic [vnu_pkg::QueuePtrW:0]       count_q;

  assign full_o  = count_q == (vnu_pkg::QueuePtrW+1)'(vnu_pkg::QueueDepth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule
`default_nettype wire

/* rtl/vnu_back.sv */
`default_nettype none
module vnu_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  vnu_pkg::cfg_t          cfg_i,
  input  wire logic              item_valid_i,
  input  vnu_pkg::fe_item_t      item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [127:0]           out_units_o,
  output logic [32:0]            out_len_o,
  output logic                   out_zero_o,
  output logic                   out_unit_o
);

  localparam int unsigned SqStages = vnu_pkg::RootW + 1;
  localparam int unsigned DvStages = vnu_pkg::QuotW + 1;

  typedef struct packed {
    logic [vnu_pkg::SqW-1:0]                          rem;
    logic [vnu_pkg::RootW-1:0]                        root;
    logic                                             big;
    logic [vnu_pkg::NumLanes-1:0][vnu_pkg::CompW-1:0] mag;
    logic [vnu_pkg::NumLanes-1:0]                     neg;
  } sq_stage_t;

  typedef struct packed {
    logic [vnu_pkg::NumLanes-1:0][vnu_pkg::RemW-1:0]  rem;
    logic [vnu_pkg::NumLanes-1:0][vnu_pkg::QuotW-1:0] quot;
    logic [vnu_pkg::LenW-1:0]                         len;
    logic                                             zero;
    logic                                             unit;
    logic [vnu_pkg::NumLanes-1:0]                     neg;
  } dv_stage_t;

  logic              en;
  logic              sq_v_q [SqStages];
  sq_stage_t         sq_q   [SqStages];
  logic              dv_v_q [DvStages];
  dv_stage_t         dv_q   [DvStages];
  logic              out_v_q;
  logic [127:0]      out_units_q;
  logic [32:0]       out_len_q;
  logic              out_zero_q;
  logic              out_unit_q;

  logic [vnu_pkg::LenW-1:0] len_d;
  logic [vnu_pkg::LenW-1:0] diff_d;
  dv_stage_t                dv0_d;
  logic [127:0]             units_d;

  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && item_valid_i;

  // Square root, one root bit per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rem  <= item_i.sum[vnu_pkg::SqW-1:0];
      sq_q[0].root <= '0;
      sq_q[0].big  <= item_i.sum[vnu_pkg::SqW];
      sq_q[0].mag  <= item_i.mag;
      sq_q[0].neg  <= item_i.neg;
    end
  end

  for (genvar s = 0; s < SqStages - 1; s++) begin : g_sqrt
    localparam int unsigned Bit = vnu_pkg::RootW - 1 - s;
    logic [vnu_pkg::SqW-1:0] trial;
    sq_stage_t               nxt;

    always_comb begin
      trial = (vnu_pkg::SqW'(sq_q[s].root) << (Bit + 1)) | (64'd1 << (2 * Bit));
      nxt   = sq_q[s];
      if (sq_q[s].rem >= trial) begin
        nxt.rem  = sq_q[s].rem - trial;
        nxt.root = sq_q[s].root | (32'd1 << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[s+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[s+1] <= sq_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) sq_q[s+1] <= nxt;
    end
  end

  // Classification of the length and set-up of the dividers.
  always_comb begin
    len_d  = sq_q[SqStages-1].big ? vnu_pkg::LenMax : {1'b0, sq_q[SqStages-1].root};
    diff_d = (len_d >= vnu_pkg::OneQ16) ? (len_d - vnu_pkg::OneQ16)
                                        : (vnu_pkg::OneQ16 - len_d);
    dv0_d.len  = len_d;
    dv0_d.zero = (len_d == '0) || (len_d < {1'b0, cfg_i.zero_thr});
    dv0_d.unit = diff_d <= {17'd0, cfg_i.unit_tol};
    dv0_d.neg  = sq_q[SqStages-1].neg;
    dv0_d.quot = '0;
    for (int i = 0; i < vnu_pkg::NumLanes; i++) begin
      dv0_d.rem[i] = {sq_q[SqStages-1].mag[i], 30'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[SqStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv0_d;
  end

  // Restoring division, one quotient bit per stage in each of the four lanes.
  for (genvar j = 0; j < DvStages - 1; j++) begin : g_div
    localparam int unsigned Bit = vnu_pkg::QuotW - 1 - j;
    logic [vnu_pkg::RemW:0] dsh;
    dv_stage_t              nxt;

    always_comb begin
      dsh = (vnu_pkg::RemW+1)'(dv_q[j].len) << Bit;
      nxt = dv_q[j];
      for (int i = 0; i < vnu_pkg::NumLanes; i++) begin
        if ({1'b0, dv_q[j].rem[i]} >= dsh) begin
          nxt.rem[i]  = vnu_pkg::RemW'({1'b0, dv_q[j].rem[i]} - dsh);
          nxt.quot[i] = dv_q[j].quot[i] | (31'd1 << Bit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[j+1] <= nxt;
    end
  end

  // Sign restore and zero-vector masking.
  always_comb begin
    for (int i = 0; i < vnu_pkg::NumLanes; i++) begin
      if (dv_q[DvStages-1].zero) begin
        units_d[i*32 +: 32] = '0;
      end else if (dv_q[DvStages-1].neg[i]) begin
        units_d[i*32 +: 32] = ~{1'b0, dv_q[DvStages-1].quot[i]} + 32'd1;
      end else begin
        units_d[i*32 +: 32] = {1'b0, dv_q[DvStages-1].quot[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[DvStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_units_q <= units_d;
      out_len_q   <= dv_q[DvStages-1].len;
      out_zero_q  <= dv_q[DvStages-1].zero;
      out_unit_q  <= dv_q[DvStages-1].unit;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_units_o = out_units_q;
  assign out_len_o   = out_len_q;
  assign out_zero_o  = out_zero_q;
  assign out_unit_o  = out_unit_q;

  a_nonzero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_zero_q |-> out_len_q != '0)
    else $error("non-zero result with zero length");

  a_len_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_len_q[32] |-> out_len_q[31:0] == '0)
    else $error("length beyond 2^32");

  a_quot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DvStages-1] && !dv_q[DvStages-1].zero |->
      dv_q[DvStages-1].quot[0] <= 31'h4000_0000 && dv_q[DvStages-1].quot[1] <= 31'h4000_0000 &&
      dv_q[DvStages-1].quot[2] <= 31'h4000_0000 && dv_q[DvStages-1].quot[3] <= 31'h4000_0000)
    else $error("quotient above 1.0");

endmodule
`default_nettype wire

/* rtl/vector4_normalize_unit.sv */
`default_nettype none
// Four-component vector normaliser. Each item carries four signed Q16.16
// components; the result item gives the Euclidean length (unsigned Q17.16,
// rounded down), each component divided by that length in signed Q2.30
// (truncated toward zero), a zero flag and a unit flag. When the output is
// not stalled, one item is accepted per cycle and one result leaves per
// cycle. There are 70 registers in line: three front stages (register,
// squaring multipliers, sum), the queue, 33 stages of the bit-per-stage
// square root and 32 stages of the four bit-per-stage dividers, then the
// output register. When the zero flag is set the four unit components are
// zero, while length and unit flag are still given. A length of zero always
// counts as zero. Registers are to be written through the configuration
// port only while no item is in flight; the block itself does not enforce
// this. Index 0 is the zero threshold (reset 1), index 1 the unit tolerance
// (reset 7); other indexes are ignored.
module vector4_normalize_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // x_in [31:0], y_in [63:32], z_in [95:64], w_in [127:96]
  input  wire logic [127:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // x_unit [31:0], y_unit [63:32], z_unit [95:64], w_unit [127:96],
  // length [160:128], zero padding [167:161]
  output logic [167:0]       m_axis_tdata,
  // is_zero [0], is_unit [1]
  output logic [1:0]         m_axis_tuser,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  vnu_pkg::cfg_t      cfg_q;
  vnu_pkg::fe_item_t  fe_item;
  vnu_pkg::fe_item_t  head;
  logic               fe_valid;
  logic               full;
  logic               empty;
  logic               push;
  logic               pop;
  logic [127:0]       units;
  logic [32:0]        len;
  logic               is_zero;
  logic               is_unit;

  // Configuration writes are always taken; the ready is tied high.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_thr <= 32'd1;
      cfg_q.unit_tol <= 16'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vnu_pkg::RegZeroThr: cfg_q.zero_thr <= cfg_data_i;
        vnu_pkg::RegUnitTol: cfg_q.unit_tol <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The front squares and sums; it stalls only when the queue is full.
  vnu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (fe_valid),
    .item_ready_i (!full),
    .item_o       (fe_item)
  );

  assign push = fe_valid && !full;

  vnu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (fe_item),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  // The back takes the root, classifies the length and divides.
  vnu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!empty),
    .item_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_units_o  (units),
    .out_len_o    (len),
    .out_zero_o   (is_zero),
    .out_unit_o   (is_unit)
  );

  assign m_axis_tdata = {7'd0, len, units};
  assign m_axis_tuser = {is_unit, is_zero};

endmodule
`default_nettype wire

/* test/tb_vector4_normalize_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_vector4_normalize_unit;

  // One normalised vector as the block should deliver it.
  typedef struct packed {
    logic [3:0][31:0] unit;
    logic [32:0]      len;
    logic             zero;
    logic             near_one;
  } norm_t;

  // Keeps the expected results in order and counts what was checked.
  class norm_scoreboard;
    norm_t       pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned zeros;
    int unsigned units;

    function void note_vector(norm_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(norm_t act);
      norm_t exp_res;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no vector pending, actual %h", $realtime, act);
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (exp_res.zero) zeros++;
      if (exp_res.near_one) units++;
      for (int i = 0; i < 4; i++) begin
        if (exp_res.unit[i] !== act.unit[i]) begin
          errors++;
          $display("%0t: component %0d expected %h actual %h", $realtime, i,
                   exp_res.unit[i], act.unit[i]);
        end
      end
      if (exp_res.len !== act.len) begin
        errors++;
        $display("%0t: length expected %h actual %h", $realtime, exp_res.len, act.len);
      end
      if (exp_res.zero !== act.zero) begin
        errors++;
        $display("%0t: zero flag expected %b actual %b", $realtime, exp_res.zero, act.zero);
      end
      if (exp_res.near_one !== act.near_one) begin
        errors++;
        $display("%0t: unit flag expected %b actual %b", $realtime,
                 exp_res.near_one, act.near_one);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [167:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  vector4_normalize_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // The predictor's own copy of the registers.
  logic [31:0] zero_thr;
  logic [15:0] unit_tol;

  norm_scoreboard sb;
  int unsigned    cycles;
  int unsigned    sent;
  bit             quiet;   // when set neither side idles
  bit             timed_out;

  localparam int unsigned CycleLimit = 400000;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Integer square root, rounded down, over a 65-bit sum.
  function automatic logic [32:0] floor_root(logic [64:0] n);
    logic [32:0] r;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      logic [32:0] t;
      t = r | (33'd1 << b);
      if (66'(t) * 66'(t) <= 66'(n)) r = t;
    end
    return r;
  endfunction

  // Works out the normalised vector from four Q16.16 components.
  function automatic norm_t normalise(logic [3:0][31:0] comp);
    norm_t       res;
    logic [32:0] mag[4];
    logic [64:0] sum;
    logic [32:0] diff;
    logic [63:0] q;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp[i][31] ? 33'h1_0000_0000 - 33'(comp[i]) : 33'(comp[i]);
      sum += 65'(mag[i]) * 65'(mag[i]);
    end
    res.len  = floor_root(sum);
    res.zero = (res.len == 0) || (res.len < 33'(zero_thr));
    for (int i = 0; i < 4; i++) begin
      q = res.zero ? 64'd0 : (64'(mag[i]) << 30) / 64'(res.len);
      res.unit[i] = comp[i][31] ? 32'(-q) : 32'(q);
    end
    diff = (res.len >= vnu_pkg::OneQ16) ? res.len - vnu_pkg::OneQ16
                                        : vnu_pkg::OneQ16 - res.len;
    res.near_one = diff <= 33'(unit_tol);
    return res;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == vnu_pkg::RegZeroThr) zero_thr = value;
    else if (idx == vnu_pkg::RegUnitTol) unit_tol = value[15:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one vector, with an occasional gap before it. The valid stays
  // high after the item is taken until the next vector or the drain.
  task automatic send_vector(logic [3:0][31:0] comp);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while (!quiet && $urandom_range(99) < 11);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= comp;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vector(normalise(comp));
    sent++;
  endtask

  // Waits until every result is in, then lets the pipeline drain.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_comp(int unsigned span);
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 * span)) - $signed(span));
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(2 * 32'h0001_0000)) - 32'sh0001_0000);
    endcase
  endfunction

  // A vector along a random axis, of either sign, with length close to one.
  function automatic logic [3:0][31:0] near_unit();
    logic [3:0][31:0] v;
    int unsigned k;
    v = '0;
    k = $urandom_range(3);
    v[k] = 32'h0001_0000 + 32'($signed($urandom_range(24)) - 12);
    if ($urandom_range(1)) v[k] = -v[k];
    return v;
  endfunction

  // The receiving side stalls now and then unless a quiet stretch is on.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= quiet || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[127:0], m_axis_tdata[160:128], m_axis_tuser[0],
                       m_axis_tuser[1]});
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [3:0][31:0] v;
    sb            = new();
    cycles        = 0;
    sent          = 0;
    quiet         = 1'b0;
    timed_out     = 1'b0;
    zero_thr      = 32'd1;
    unit_tol      = 16'd7;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = vnu_pkg::RegZeroThr;
    cfg_data_i    = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed vectors under the reset settings.
    send_vector('0);                                  // zero length
    send_vector({4{32'h8000_0000}});                  // largest length
    send_vector({4{32'h7fff_ffff}});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0001_0000}); // exactly one
    send_vector({32'h0, 32'h0, 32'hffff_0000, 32'h0});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0001_0007}); // edge of tolerance
    send_vector({32'h0, 32'h0, 32'h0, 32'h0000_fff8});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0000_fff9});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0000_0001}); // smallest length
    send_vector({32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h1});
    send_vector({32'h8000_0000, 32'h0, 32'h0, 32'h0});
    send_vector({32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1});
    send_vector({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_vector({32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a988});
    drain();

    // Threshold and tolerance of zero, and writes outside the register list.
    write_reg(vnu_pkg::RegZeroThr, 32'd0);
    write_reg(vnu_pkg::RegUnitTol, 32'hffff_0000);
    write_reg(2'd2, 32'hffff_ffff);
    write_reg(2'd3, 32'h1234_5678);
    send_vector('0);
    send_vector({32'h0, 32'h0, 32'h0, 32'h1});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0001_0001});
    drain();

    // Largest threshold and tolerance, then the random phases.
    write_reg(vnu_pkg::RegZeroThr, 32'hffff_ffff);
    write_reg(vnu_pkg::RegUnitTol, 32'h0000_ffff);
    send_vector({4{32'h8000_0000}});
    send_vector({32'h7fff_ffff, 32'h0, 32'h0, 32'h0});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0});
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(vnu_pkg::RegZeroThr, 32'd1);
          write_reg(vnu_pkg::RegUnitTol, 32'd7);
        end
        1: begin
          write_reg(vnu_pkg::RegZeroThr, 32'h0000_8000);
          write_reg(vnu_pkg::RegUnitTol, 32'd0);
        end
        2: begin
          write_reg(vnu_pkg::RegZeroThr, $urandom);
          write_reg(vnu_pkg::RegUnitTol, $urandom);
        end
        3: begin
          write_reg(vnu_pkg::RegZeroThr, 32'd0);
          write_reg(vnu_pkg::RegUnitTol, 32'h0000_0100);
        end
        default: begin
          write_reg(vnu_pkg::RegZeroThr, $urandom_range(32'h0002_0000));
          write_reg(vnu_pkg::RegUnitTol, $urandom_range(64));
        end
      endcase
      for (int n = 0; n < 225; n++) begin
        // In phase 2, a stretch in the middle of the run with no idling at all.
        quiet = (phase == 2) && (n >= 40) && (n < 160);
        if ($urandom_range(5) == 0) v = near_unit();
        else for (int i = 0; i < 4; i++) v[i] = rand_comp(32'd1 << $urandom_range(31));
        send_vector(v);
      end
      quiet = 1'b0;
      drain();
    end

    $display("Sent %0d vectors over eight register settings; %0d results checked.",
             sent, sb.checked);
    $display("Results with the zero flag: %0d, with the unit flag: %0d.", sb.zeros, sb.units);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
